FILE: src/rtp_fua_pkg.sv
// ----------------------------------------------------------------------------
// RTP H.264 FU-A packetizer package
// Shared widths, register indexes and RTP/FU-A header constants.
// ----------------------------------------------------------------------------
package rtp_fua_pkg;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NAL_SIZE_W = 21;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SSRC_W     = 32;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned LIMIT_W    = 16;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PACKET_LIMIT = 8'd0,
    REG_SOURCE_ID    = 8'd1
  } cfg_reg_e;

  // Parameter defaults
  localparam int unsigned MAX_PACKET_DEFAULT = 1500;
  localparam int unsigned MAX_NAL_DEFAULT    = 1048576;

  // Register reset values
  localparam int unsigned PACKET_LIMIT_RESET = 1500;
  localparam int unsigned MIN_PACKET_LIMIT   = 15;

  // RTP header
  localparam logic [BYTE_W-1:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [6:0]        RTP_PT_DYNAMIC   = 7'd96;
  localparam int unsigned       RTP_HDR_BYTES    = 12;

  // FU-A
  localparam logic [4:0] FU_A_TYPE     = 5'd28;
  localparam int unsigned FU_HDR_BYTES = 2;

endpackage

FILE: src/rtp_h264_fu_a_packetizer.sv
// ----------------------------------------------------------------------------
// RTP H.264 FU-A packetizer
// Turns a NAL byte stream into RTP packets, single NAL or FU-A fragments.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one NAL byte per beat. nal_size, time_value and
//    end_of_frame are sampled on a NAL's first byte only.
//  - Output channel: one packet byte per beat. packet_start marks the first
//    header byte, packet_end the last packet byte, run_last the last beat
//    caused by one input beat, size_error a rejected NAL (no packet bytes).
//  - Config channel: index 0 writes packet_limit, index 1 writes source_id.
//    Write only while the block is idle; cfg_ready_o is always high.
//  - Timing: a result is registered and appears in the cycle after its input beat is taken.
//  - Throughput: one input beat per cycle inside a packet's payload. A beat
//    that opens a packet drives 13 output beats (15 for an FU-A fragment),
//    and the next input beat is taken in the cycle of its last output beat.
//    The first byte of a fragmented NAL is held and yields no output.
//  - The single run register between the channels sets these figures; a
//    receiver stall holds it and, through in_ready_o, the sender.
//  - Reset: sequence number restarts at 1, packet_limit 1500, source_id 0.
// ----------------------------------------------------------------------------
module rtp_h264_fu_a_packetizer #(
  parameter int unsigned MAX_PACKET = rtp_fua_pkg::MAX_PACKET_DEFAULT,
  parameter int unsigned MAX_NAL    = rtp_fua_pkg::MAX_NAL_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rtp_fua_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rtp_fua_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // NAL byte input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rtp_fua_pkg::BYTE_W-1:0]      nal_byte_i,
  input  logic [rtp_fua_pkg::NAL_SIZE_W-1:0]  nal_size_i,
  input  logic [rtp_fua_pkg::TIME_W-1:0]      time_value_i,
  input  logic                                end_of_frame_i,
  // packet byte output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rtp_fua_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                                packet_start_o,
  output logic                                packet_end_o,
  output logic                                run_last_o,
  output logic                                size_error_o
);
  import rtp_fua_pkg::*;

  localparam int unsigned LIM_W   = $clog2(MAX_PACKET + 1);
  localparam int unsigned REM_W   = $clog2(MAX_NAL + 1);
  localparam int unsigned EFF_RST = (PACKET_LIMIT_RESET < MIN_PACKET_LIMIT ||
                                     PACKET_LIMIT_RESET > MAX_PACKET) ?
                                    MAX_PACKET : PACKET_LIMIT_RESET;
  localparam int unsigned WHOLE_RST = EFF_RST - RTP_HDR_BYTES;
  localparam int unsigned FRAG_RST  = EFF_RST - RTP_HDR_BYTES - FU_HDR_BYTES;

  typedef enum logic [3:0] {
    S_VER, S_PT, S_SEQ_HI, S_SEQ_LO,
    S_TS3, S_TS2, S_TS1, S_TS0,
    S_SSRC3, S_SSRC2, S_SSRC1, S_SSRC0,
    S_FU_IND, S_FU_HDR, S_DATA
  } slot_e;

  // --------------------------------------------------------------------------
  // Configuration registers (limit kept as ready-made payload bounds)
  // --------------------------------------------------------------------------
  logic [LIM_W-1:0]  whole_lim_q, frag_lim_q;
  logic [SSRC_W-1:0] source_id_q;
  logic [LIMIT_W-1:0] cfg_limit;
  logic [LIM_W-1:0]   eff_limit;
  logic               cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign cfg_limit   = cfg_data_i[LIMIT_W-1:0];

  // clamp out-of-range limits to the largest packet
  always_comb begin
    if (cfg_limit < LIMIT_W'(MIN_PACKET_LIMIT) || 32'(cfg_limit) > MAX_PACKET) begin
      eff_limit = LIM_W'(MAX_PACKET);
    end else begin
      eff_limit = cfg_limit[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_lim_q <= LIM_W'(WHOLE_RST);
      frag_lim_q  <= LIM_W'(FRAG_RST);
      source_id_q <= '0;
    end else if (cfg_fire) begin
      if (cfg_index_i == REG_PACKET_LIMIT) begin
        whole_lim_q <= eff_limit - LIM_W'(RTP_HDR_BYTES);
        frag_lim_q  <= eff_limit - LIM_W'(RTP_HDR_BYTES + FU_HDR_BYTES);
      end else if (cfg_index_i == REG_SOURCE_ID) begin
        source_id_q <= cfg_data_i[SSRC_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // NAL tracking state
  // --------------------------------------------------------------------------
  logic [SEQ_W-1:0]  next_seq_q;
  logic              active_q;      // a NAL is in progress
  logic              split_q;       // current NAL goes out as FU-A
  logic              first_frag_q;  // next fragment is the first one
  logic [REM_W-1:0]  rem_q;         // bytes of the NAL not yet taken
  logic [LIM_W-1:0]  frag_left_q;   // bytes left in the open fragment
  logic [TIME_W-1:0] held_time_q;
  logic              held_eof_q;
  logic [BYTE_W-1:0] held_header_q;

  // Run register: everything needed to replay one beat's results
  logic              run_valid_q;
  slot_e             slot_q;
  logic              run_err_q, run_fu_q, run_marker_q, run_end_q;
  logic [SEQ_W-1:0]  run_seq_q;
  logic [TIME_W-1:0] run_time_q;
  logic [BYTE_W-1:0] run_fu_ind_q, run_fu_hdr_q, run_data_q;

  logic in_fire, out_fire, run_done;

  assign out_fire   = run_valid_q & out_ready_i;
  assign run_done   = slot_q == S_DATA;
  assign in_ready_o = !run_valid_q || (out_ready_i && run_done);
  assign in_fire    = in_valid_i & in_ready_o;

  // --------------------------------------------------------------------------
  // Per-beat decision
  // --------------------------------------------------------------------------
  logic              size_bad, fits_whole, new_frag, frag_final;
  logic              hdr_d, fu_d, load_d, end_d, marker_d;
  logic [LIM_W-1:0]  frag_sel, frag_next;
  logic [REM_W-1:0]  size_rem;
  logic [NAL_SIZE_W-1:0] rem_ext, frag_lim_ext, whole_lim_ext;

  assign rem_ext       = NAL_SIZE_W'(rem_q);
  assign frag_lim_ext  = NAL_SIZE_W'(frag_lim_q);
  assign whole_lim_ext = NAL_SIZE_W'(whole_lim_q);
  assign size_bad      = (nal_size_i == '0) || (32'(nal_size_i) > MAX_NAL);
  assign fits_whole    = nal_size_i <= whole_lim_ext;
  assign size_rem      = nal_size_i[REM_W-1:0] - REM_W'(1);
  assign new_frag      = frag_left_q == '0;
  assign frag_final    = rem_ext <= frag_lim_ext;
  assign frag_sel      = frag_final ? rem_q[LIM_W-1:0] : frag_lim_q;
  assign frag_next     = (new_frag ? frag_sel : frag_left_q) - LIM_W'(1);

  always_comb begin
    hdr_d    = 1'b0;
    fu_d     = 1'b0;
    load_d   = 1'b1;
    end_d    = 1'b0;
    marker_d = 1'b0;
    if (!active_q) begin
      if (size_bad) begin
        hdr_d = 1'b0;
      end else if (fits_whole) begin
        hdr_d    = 1'b1;
        marker_d = end_of_frame_i;
        end_d    = nal_size_i == NAL_SIZE_W'(1);
      end else begin
        // hold the NAL header byte, nothing to send yet
        load_d = 1'b0;
      end
    end else if (!split_q) begin
      end_d = rem_q == REM_W'(1);
    end else begin
      hdr_d    = new_frag;
      fu_d     = new_frag;
      marker_d = held_eof_q & frag_final;
      end_d    = frag_next == '0;
    end
  end

  // --------------------------------------------------------------------------
  // Tracking state update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q    <= SEQ_W'(1);
      active_q      <= 1'b0;
      split_q       <= 1'b0;
      first_frag_q  <= 1'b0;
      rem_q         <= '0;
      frag_left_q   <= '0;
      held_time_q   <= '0;
      held_eof_q    <= 1'b0;
      held_header_q <= '0;
    end else if (in_fire) begin
      if (hdr_d) begin
        next_seq_q <= next_seq_q + SEQ_W'(1);
      end
      if (!active_q) begin
        if (!size_bad) begin
          held_time_q   <= time_value_i;
          held_eof_q    <= end_of_frame_i;
          held_header_q <= nal_byte_i;
          rem_q         <= size_rem;
          frag_left_q   <= '0;
          split_q       <= !fits_whole;
          first_frag_q  <= !fits_whole;
          active_q      <= !(fits_whole && nal_size_i == NAL_SIZE_W'(1));
        end
      end else begin
        // advance through the NAL
        rem_q <= rem_q - REM_W'(1);
        if (rem_q == REM_W'(1)) begin
          active_q <= 1'b0;
        end
        if (split_q) begin
          frag_left_q <= (rem_q == REM_W'(1)) ? '0 : frag_next;
          if (new_frag) begin
            first_frag_q <= 1'b0;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run register and slot sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      slot_q      <= S_DATA;
    end else if (in_fire && load_d) begin
      run_valid_q <= 1'b1;
      slot_q      <= hdr_d ? S_VER : S_DATA;
    end else if (out_fire) begin
      if (run_done) begin
        run_valid_q <= 1'b0;
      end else if (slot_q == S_SSRC0 && !run_fu_q) begin
        slot_q <= S_DATA;
      end else begin
        slot_q <= slot_e'(slot_q + 4'd1);
      end
    end
  end

  // payload of the run, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && load_d) begin
      run_err_q    <= !active_q && size_bad;
      run_fu_q     <= fu_d;
      run_marker_q <= marker_d;
      run_end_q    <= end_d;
      run_seq_q    <= next_seq_q;
      run_time_q   <= active_q ? held_time_q : time_value_i;
      run_fu_ind_q <= {held_header_q[7:5], FU_A_TYPE};
      run_fu_hdr_q <= {first_frag_q, frag_final, 1'b0, held_header_q[4:0]};
      run_data_q   <= nal_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Output byte select
  // --------------------------------------------------------------------------
  always_comb begin
    out_byte_o     = '0;
    packet_start_o = 1'b0;
    packet_end_o   = 1'b0;
    unique case (slot_q)
      S_VER: begin
        out_byte_o     = RTP_VERSION_BYTE;
        packet_start_o = 1'b1;
      end
      S_PT:     out_byte_o = {run_marker_q, RTP_PT_DYNAMIC};
      S_SEQ_HI: out_byte_o = run_seq_q[15:8];
      S_SEQ_LO: out_byte_o = run_seq_q[7:0];
      S_TS3:    out_byte_o = run_time_q[31:24];
      S_TS2:    out_byte_o = run_time_q[23:16];
      S_TS1:    out_byte_o = run_time_q[15:8];
      S_TS0:    out_byte_o = run_time_q[7:0];
      S_SSRC3:  out_byte_o = source_id_q[31:24];
      S_SSRC2:  out_byte_o = source_id_q[23:16];
      S_SSRC1:  out_byte_o = source_id_q[15:8];
      S_SSRC0:  out_byte_o = source_id_q[7:0];
      S_FU_IND: out_byte_o = run_fu_ind_q;
      S_FU_HDR: out_byte_o = run_fu_hdr_q;
      S_DATA: begin
        if (!run_err_q) begin
          out_byte_o   = run_data_q;
          packet_end_o = run_end_q;
        end
      end
      default: out_byte_o = '0;
    endcase
  end

  assign out_valid_o  = run_valid_q;
  assign run_last_o   = run_done;
  assign size_error_o = run_err_q && run_done;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fu_slots_only_in_fragments: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q && (slot_q == S_FU_IND || slot_q == S_FU_HDR) |-> run_fu_q)
    else $error("FU-A header slot reached on a non-fragment run");

  a_error_run_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q && run_err_q |-> slot_q == S_DATA)
    else $error("size error run is longer than one beat");

  a_take_only_on_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && run_valid_q |-> out_ready_i && slot_q == S_DATA)
    else $error("input taken while run still has beats pending");

  a_seq_advances_per_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && hdr_d |=> next_seq_q == $past(next_seq_q) + SEQ_W'(1))
    else $error("sequence number did not advance with a new packet");

  a_idle_no_open_fragment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> frag_left_q == '0)
    else $error("fragment left open with no NAL in progress");

endmodule
